### rtl/core/band_rms_loudness_meter_defines.svh
// Assertion helpers used by the meter's back end.
`ifndef BAND_RMS_LOUDNESS_METER_DEFINES_SVH
`define BAND_RMS_LOUDNESS_METER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BLRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BLRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/blrm_pkg.sv
// ----------------------------------------------------------------------------
// blrm_pkg
// Types, constants and helpers of the band RMS loudness meter.
// ----------------------------------------------------------------------------
package blrm_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int ENERGY_W     = 61;
  localparam int ITEMS_W      = 14;
  localparam int SUM_W        = 51;
  localparam int FLOOR_E_W    = 48;
  localparam int DB_W         = 16;
  localparam int RATE_W       = 18;
  localparam int NBINS_W      = 13;
  localparam int CFG_W        = 48;
  localparam int BAND_W       = 3;
  localparam int EDGE2_W      = 14;
  localparam int LAST_BAND    = 7;
  localparam int LOG_FRAC     = 24;
  localparam int LOG_BIAS     = 35;
  localparam int MANT_W       = 32;
  localparam int PROD_W       = 60;
  localparam int JOB_DEPTH    = 2;
  localparam int DEF_MAX_BINS = 4096;

  localparam logic [27:0] DB_PER_LOG2 = 28'd50504453;

  localparam logic [NBINS_W-1:0]   NUM_BINS_RST     = 13'd129;
  localparam logic [RATE_W-1:0]    SAMPLE_RATE_RST  = 18'd48000;
  localparam logic [DB_W-1:0]      FLOOR_DB_RST     = 16'hA600;
  localparam logic [FLOOR_E_W-1:0] FLOOR_ENERGY_RST = 48'd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_re;
    logic signed [SAMPLE_W-1:0] left_im;
    logic signed [SAMPLE_W-1:0] right_re;
    logic signed [SAMPLE_W-1:0] right_im;
  } blrm_in_t;

  typedef struct packed {
    logic signed [DB_W-1:0] loudness_db;
    logic                   at_floor;
  } blrm_out_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [ITEMS_W-1:0]  items;
    logic                last;
  } blrm_job_t;

  typedef enum logic [1:0] {
    CFG_NUM_BINS,
    CFG_SAMPLE_RATE,
    CFG_FLOOR_DB,
    CFG_FLOOR_ENERGY
  } blrm_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_CHK,
    ST_NORM,
    ST_SQR,
    ST_MUL,
    ST_RND,
    ST_OUT
  } blrm_state_t;

  // Twice the upper edge of each octave band below the last, in Hz.
  function automatic logic [EDGE2_W-1:0] band_edge2(input logic [BAND_W-1:0] band);
    logic [EDGE2_W-1:0] e;
    case (band)
      3'd0:    e = 14'd180;
      3'd1:    e = 14'd360;
      3'd2:    e = 14'd720;
      3'd3:    e = 14'd1440;
      3'd4:    e = 14'd2880;
      3'd5:    e = 14'd5760;
      3'd6:    e = 14'd11520;
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

### rtl/core/blrm_front.sv
// ----------------------------------------------------------------------------
// blrm_front
// Takes bins, accumulates band energy and hands closed bands to the back end.
// ----------------------------------------------------------------------------
module blrm_front #(
  parameter int MAX_BINS = blrm_pkg::DEF_MAX_BINS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  blrm_pkg::blrm_in_t            in_word,
  input  logic [blrm_pkg::NBINS_W-1:0]  num_bins,
  input  logic [blrm_pkg::RATE_W-1:0]   sample_rate,
  input  logic                          job_full,
  output logic                          job_push,
  output blrm_pkg::blrm_job_t           job_word
);
  import blrm_pkg::*;

  localparam int CNT_W = $clog2(MAX_BINS);
  localparam int LHS_W = CNT_W + RATE_W;
  localparam int N_W   = $clog2(MAX_BINS + 1);
  localparam int RHS_W = EDGE2_W + N_W;
  localparam int SQ_W  = 2 * SAMPLE_W;
  localparam int E_W   = SQ_W + 2;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BAND_W-1:0]   band_r, band_nxt;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [ITEMS_W-1:0]  items_r, items_nxt;

  logic [31:0]         nb_ext, n_ext;
  logic [N_W-1:0]      n;
  logic                is_last, freq_close, will_close, accept;
  logic [LHS_W-1:0]    lhs;
  logic [RHS_W-1:0]    rhs;
  logic signed [SQ_W-1:0] sq_lr, sq_li, sq_rr, sq_ri;
  logic [E_W-1:0]      e_bin;
  logic [ENERGY_W-1:0] energy_new;
  logic [ITEMS_W-1:0]  items_new;

  // Clamp the bin count to the supported range.
  always_comb begin
    nb_ext = 32'(num_bins);
    if (nb_ext == 32'd0) begin
      n_ext = 32'd1;
    end else if (nb_ext > 32'(MAX_BINS)) begin
      n_ext = 32'(MAX_BINS);
    end else begin
      n_ext = nb_ext;
    end
    n = n_ext[N_W-1:0];
  end

  assign is_last    = 32'(cnt_r) >= (n_ext - 32'd1);
  assign lhs        = LHS_W'(cnt_r) * LHS_W'(sample_rate);
  assign rhs        = RHS_W'(band_edge2(band_r)) * RHS_W'(n);
  assign freq_close = (band_r < BAND_W'(LAST_BAND)) && (64'(lhs) > 64'(rhs));
  assign will_close = is_last || freq_close;

  // Stall only for a bin that would hand over a band.
  assign full   = job_full && will_close;
  assign accept = push && !full;

  assign sq_lr = in_word.left_re * in_word.left_re;
  assign sq_li = in_word.left_im * in_word.left_im;
  assign sq_rr = in_word.right_re * in_word.right_re;
  assign sq_ri = in_word.right_im * in_word.right_im;
  assign e_bin = E_W'($unsigned(sq_lr)) + E_W'($unsigned(sq_li))
               + E_W'($unsigned(sq_rr)) + E_W'($unsigned(sq_ri));

  assign energy_new = energy_r + ENERGY_W'(e_bin);
  assign items_new  = items_r + ITEMS_W'(2);

  always_comb begin
    cnt_nxt    = cnt_r;
    band_nxt   = band_r;
    energy_nxt = energy_r;
    items_nxt  = items_r;
    job_push   = 1'b0;
    job_word.energy = energy_new;
    job_word.items  = items_new;
    job_word.last   = is_last;
    if (accept) begin
      if (is_last) begin
        job_push   = 1'b1;
        cnt_nxt    = '0;
        band_nxt   = '0;
        energy_nxt = '0;
        items_nxt  = '0;
      end else if (freq_close) begin
        job_push   = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        band_nxt   = band_r + 1'b1;
        energy_nxt = '0;
        items_nxt  = '0;
      end else begin
        cnt_nxt    = cnt_r + 1'b1;
        energy_nxt = energy_new;
        items_nxt  = items_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      band_r   <= '0;
      energy_r <= '0;
      items_r  <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      band_r   <= band_nxt;
      energy_r <= energy_nxt;
      items_r  <= items_nxt;
    end
  end

endmodule

### rtl/core/blrm_job_fifo.sv
// ----------------------------------------------------------------------------
// blrm_job_fifo
// Short queue of closed bands between the front and back ends.
// ----------------------------------------------------------------------------
module blrm_job_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  blrm_pkg::blrm_job_t wr_word,
  output logic                full,
  input  logic                rd_en,
  output blrm_pkg::blrm_job_t rd_word,
  output logic                empty
);
  import blrm_pkg::*;

  localparam int PTR_W = $clog2(JOB_DEPTH);
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  blrm_job_t        mem_r [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full    = count_r == CNT_W'(JOB_DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_word = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/blrm_back.sv
// ----------------------------------------------------------------------------
// blrm_back
// Divides band energy by count, sums band means and converts to dB, or reports the floor.
// ----------------------------------------------------------------------------
`include "band_rms_loudness_meter_defines.svh"

module blrm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [blrm_pkg::DB_W-1:0]       floor_db,
  input  logic [blrm_pkg::FLOOR_E_W-1:0]  floor_energy,
  input  logic                            job_empty,
  input  blrm_pkg::blrm_job_t             job_word,
  output logic                            job_pop,
  output logic                            empty,
  input  logic                            pop,
  output blrm_pkg::blrm_out_t             out_word
);
  import blrm_pkg::*;

  localparam int CNT_W = $clog2(ENERGY_W);
  localparam int MSB_W = $clog2(SUM_W);

  blrm_state_t         state_r, state_nxt;
  logic [ENERGY_W-1:0] num_r, num_nxt;
  logic [ENERGY_W-1:0] quo_r, quo_nxt;
  logic [ITEMS_W-1:0]  den_r, den_nxt;
  logic [ITEMS_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                last_r, last_nxt;
  logic [MSB_W-1:0]    msb_r, msb_nxt;
  logic [MANT_W-1:0]   m_r, m_nxt;
  logic [LOG_FRAC-1:0] frac_r, frac_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  blrm_out_t           res_r, res_nxt;
  blrm_out_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [ITEMS_W:0]    trial;
  logic                trial_ge;
  logic                at_floor;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_sh;
  logic signed [31:0]  lg;
  logic signed [PROD_W-1:0] rnd;
  logic signed [19:0]  db_wide;

  assign trial    = {rem_r, num_r[ENERGY_W-1]};
  assign trial_ge = trial >= {1'b0, den_r};
  assign at_floor = sum_r <= {floor_energy, 3'b000};
  assign sq       = 64'(m_r) * 64'(m_r);
  assign sq_sh    = sq[2*MANT_W-1:MANT_W-1];
  assign lg       = ((32'($signed({1'b0, msb_r})) - 32'sd35) <<< LOG_FRAC)
                  + $signed({8'b0, frac_r});
  assign rnd      = prod_r + (PROD_W'(1) <<< 39);
  assign db_wide  = rnd[PROD_W-1:40];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          state_nxt = (job_word.items == '0) ? ST_ACC : ST_DIV;
        end
      end
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_r ? ST_CHK : ST_IDLE;
      ST_CHK:  state_nxt = at_floor ? ST_OUT : ST_NORM;
      ST_NORM: if (sum_r[SUM_W-1]) state_nxt = ST_SQR;
      ST_SQR:  if (cnt_r == CNT_W'(LOG_FRAC - 1)) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and handshakes.
  always_comb begin
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    msb_nxt       = msb_r;
    m_nxt         = m_r;
    frac_nxt      = frac_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !pop;
    job_pop       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop  = 1'b1;
          num_nxt  = job_word.energy;
          den_nxt  = job_word.items;
          last_nxt = job_word.last;
          rem_nxt  = '0;
          quo_nxt  = '0;
          cnt_nxt  = CNT_W'(ENERGY_W - 1);
        end
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? ITEMS_W'(trial - {1'b0, den_r}) : trial[ITEMS_W-1:0];
        quo_nxt = {quo_r[ENERGY_W-2:0], trial_ge};
        num_nxt = {num_r[ENERGY_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
      ST_ACC: begin
        sum_nxt = sum_r + quo_r[SUM_W-1:0];
        msb_nxt = MSB_W'(SUM_W - 1);
      end
      ST_CHK: begin
        res_nxt.loudness_db = floor_db;
        res_nxt.at_floor    = at_floor;
      end
      ST_NORM: begin
        if (sum_r[SUM_W-1]) begin
          m_nxt    = sum_r[SUM_W-1:SUM_W-MANT_W];
          frac_nxt = '0;
          cnt_nxt  = '0;
        end else begin
          sum_nxt = {sum_r[SUM_W-2:0], 1'b0};
          msb_nxt = msb_r - 1'b1;
        end
      end
      ST_SQR: begin
        // Square, keep Q1.31, take one fraction bit.
        if (sq_sh[MANT_W]) begin
          m_nxt    = sq_sh[MANT_W:1];
          frac_nxt = {frac_r[LOG_FRAC-2:0], 1'b1};
        end else begin
          m_nxt    = sq_sh[MANT_W-1:0];
          frac_nxt = {frac_r[LOG_FRAC-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_MUL: begin
        prod_nxt = PROD_W'(lg) * $signed({1'b0, DB_PER_LOG2});
      end
      ST_RND: begin
        res_nxt.at_floor = 1'b0;
        if (db_wide > 20'sd32767) begin
          res_nxt.loudness_db = 16'sh7FFF;
        end else if (db_wide < -20'sd32768) begin
          res_nxt.loudness_db = 16'sh8000;
        end else begin
          res_nxt.loudness_db = db_wide[DB_W-1:0];
        end
      end
      ST_OUT: begin
        if (!out_valid_r) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
    msb_r  <= msb_nxt;
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty    = !out_valid_r;
  assign out_word = out_r;

  `BLRM_ASSERT_IMP(a_pop_only_idle, job_pop, state_r == ST_IDLE, "band taken while busy")
  `BLRM_ASSERT_IMP(a_norm_nonzero, state_r == ST_NORM, sum_r != '0, "normalising a zero sum")
  `BLRM_ASSERT_IMP(a_mant_norm, state_r == ST_SQR, m_r[MANT_W-1], "mantissa lost its top bit")
  `BLRM_ASSERT_NXT(a_div_exit, state_r == ST_DIV, state_r == ST_DIV || state_r == ST_ACC, "divide left early")

endmodule

### rtl/core/band_rms_loudness_meter.sv
// ----------------------------------------------------------------------------
// band_rms_loudness_meter
// Octave band RMS loudness of a two-ear spectrum, one bin per word.
//
//   channel   direction  handshake            payload
//   input     in         push / full          in_word   (blrm_in_t)
//   result    out        pop / empty          out_word  (blrm_out_t)
//   config    in         cfg_we               cfg_index, cfg_wdata
//
// A bin word is taken whenever push is high and full is low; full rises only
// for a bin that closes a band while both band queue slots are taken.
// Each closed band goes through a bit-serial divide in the back end, skipped
// when it holds no items; the final band then adds the log conversion unless the sum is at or below the floor.
// A result waits in its output register; bins keep flowing until the next result also waits and the band queue fills.
// Reset (rst_n low at a clock edge) loads register defaults and clears sums.
// ----------------------------------------------------------------------------
module band_rms_loudness_meter #(
  parameter int MAX_BINS = blrm_pkg::DEF_MAX_BINS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  blrm_pkg::blrm_in_t          in_word,
  output logic                        empty,
  input  logic                        pop,
  output blrm_pkg::blrm_out_t         out_word,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [blrm_pkg::CFG_W-1:0]  cfg_wdata
);
  import blrm_pkg::*;

  logic [NBINS_W-1:0]   num_bins_r;
  logic [RATE_W-1:0]    sample_rate_r;
  logic [DB_W-1:0]      floor_db_r;
  logic [FLOOR_E_W-1:0] floor_energy_r;

  logic      job_full, job_empty, job_push, job_pop;
  blrm_job_t job_in, job_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r     <= NUM_BINS_RST;
      sample_rate_r  <= SAMPLE_RATE_RST;
      floor_db_r     <= FLOOR_DB_RST;
      floor_energy_r <= FLOOR_ENERGY_RST;
    end else if (cfg_we) begin
      unique case (blrm_cfg_idx_t'(cfg_index))
        CFG_NUM_BINS:     num_bins_r     <= cfg_wdata[NBINS_W-1:0];
        CFG_SAMPLE_RATE:  sample_rate_r  <= cfg_wdata[RATE_W-1:0];
        CFG_FLOOR_DB:     floor_db_r     <= cfg_wdata[DB_W-1:0];
        CFG_FLOOR_ENERGY: floor_energy_r <= cfg_wdata[FLOOR_E_W-1:0];
        default: ;
      endcase
    end
  end

  blrm_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_word     (in_word),
    .num_bins    (num_bins_r),
    .sample_rate (sample_rate_r),
    .job_full    (job_full),
    .job_push    (job_push),
    .job_word    (job_in)
  );

  blrm_job_fifo u_job_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_word (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_word (job_out),
    .empty   (job_empty)
  );

  blrm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .floor_db     (floor_db_r),
    .floor_energy (floor_energy_r),
    .job_empty    (job_empty),
    .job_word     (job_out),
    .job_pop      (job_pop),
    .empty        (empty),
    .pop          (pop),
    .out_word     (out_word)
  );

endmodule

### tb/tb_band_rms_loudness_meter.sv
// ----------------------------------------------------------------------------
// tb_band_rms_loudness_meter
// Self-checking bench for the band RMS loudness meter. A short table of edge
// case bins comes first, then clamp and back-pressure cases and random spectra
// under several register settings and idling patterns. Every accepted bin goes
// through a bit-exact model of the band sums and the log stage. Every popped
// word is compared with the oldest predicted loudness.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_band_rms_loudness_meter;
  import blrm_pkg::*;

  localparam int NBIN_CAP = 4096;
  localparam logic signed [SAMPLE_W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMIN = 24'sh800000;
  localparam int unsigned OCT_EDGE [7] = '{90, 180, 360, 720, 1440, 2880, 5760};

  typedef struct {
    blrm_in_t  w;
    bit        pin;
    blrm_out_t val;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  blrm_in_t in_word = '0;
  logic empty;
  logic pop = 1'b0;
  blrm_out_t out_word;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // pinned loudness for directed rows, travels with the bin word
  logic pin_on = 1'b0;
  blrm_out_t pin_val = '0;

  band_rms_loudness_meter uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
    .empty(empty), .pop(pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  // model state and registers
  logic [NBINS_W-1:0]   m_nbins;
  logic [RATE_W-1:0]    m_rate;
  logic signed [DB_W-1:0] m_floor_db;
  logic [FLOOR_E_W-1:0] m_floor_e;
  int                   m_bin;
  logic [3:0]           m_band;
  logic [ENERGY_W-1:0]  m_energy;
  logic [ITEMS_W-1:0]   m_items;
  logic [SUM_W-1:0]     m_sum;

  blrm_out_t loudness_q[$];
  blrm_out_t predicted;
  int errors = 0;
  int send_pct = 0;
  int stall_pct = 0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;

  function automatic longint unsigned mag_sq(input logic signed [SAMPLE_W-1:0] s);
    longint v;
    v = s;
    return longint'(v * v);
  endfunction

  function automatic logic signed [DB_W-1:0] db_of_sum(input logic [SUM_W-1:0] s);
    int msb;
    longint unsigned m;
    longint unsigned u;
    longint frac, lg, prod, res;
    msb = 0;
    frac = 0;
    while (msb < 63 && (64'(s) >> (msb + 1)) != 0) msb++;
    m = (msb >= 31) ? (64'(s) >> (msb - 31)) : (64'(s) << (31 - msb));
    for (int k = 0; k < LOG_FRAC; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    lg = (longint'(msb) - 35) * (64'sd1 << 24) + frac;
    prod = lg * 64'sd50504453;
    u = prod + (64'sd1 << 39) + (64'sd1 << 60);
    res = longint'(u >> 40) - (64'sd1 << 20);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[DB_W-1:0];
  endfunction

  function automatic void close_band();
    if (m_items != 0) m_sum = m_sum + SUM_W'(m_energy / m_items);
    m_energy = '0;
    m_items = '0;
    m_band = m_band + 1'b1;
  endfunction

  // advance the meter by one bin; returns 1 when a loudness word falls out
  function automatic bit meter_bin(input blrm_in_t w, output blrm_out_t r);
    longint unsigned n, e;
    bit floor_hit;
    n = m_nbins;
    if (n < 1) n = 1;
    if (n > NBIN_CAP) n = NBIN_CAP;
    e = mag_sq(w.left_re) + mag_sq(w.left_im) + mag_sq(w.right_re) + mag_sq(w.right_im);
    m_energy = m_energy + ENERGY_W'(e);
    m_items = m_items + ITEMS_W'(2);
    r = '0;
    if (longint'(m_bin) >= n - 1) begin
      close_band();
      floor_hit = 64'(m_sum) <= 64'(m_floor_e) * 8;
      r.loudness_db = floor_hit ? m_floor_db : db_of_sum(m_sum);
      r.at_floor = floor_hit;
      m_bin = 0;
      m_band = '0;
      m_energy = '0;
      m_items = '0;
      m_sum = '0;
      return 1'b1;
    end
    if (m_band < 7) begin
      if (64'(m_bin) * 64'(m_rate) > 64'(OCT_EDGE[m_band]) * 2 * n) close_band();
    end
    m_bin++;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      m_nbins = NUM_BINS_RST;
      m_rate = SAMPLE_RATE_RST;
      m_floor_db = FLOOR_DB_RST;
      m_floor_e = FLOOR_ENERGY_RST;
      m_bin = 0;
      m_band = '0;
      m_energy = '0;
      m_items = '0;
      m_sum = '0;
    end else begin
      if (cfg_we) begin
        case (blrm_cfg_idx_t'(cfg_index))
          CFG_NUM_BINS:     m_nbins = cfg_wdata[NBINS_W-1:0];
          CFG_SAMPLE_RATE:  m_rate = cfg_wdata[RATE_W-1:0];
          CFG_FLOOR_DB:     m_floor_db = cfg_wdata[DB_W-1:0];
          CFG_FLOOR_ENERGY: m_floor_e = cfg_wdata[FLOOR_E_W-1:0];
        endcase
      end
      if (pop && !empty) begin
        if (loudness_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word db=%0d floor=%0b",
                                     out_word.loudness_db, out_word.at_floor);
        end else begin
          predicted = loudness_q.pop_front();
          if (out_word.loudness_db !== predicted.loudness_db ||
              out_word.at_floor !== predicted.at_floor) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: db exp %0d got %0d, floor exp %0b got %0b",
                       predicted.loudness_db, out_word.loudness_db,
                       predicted.at_floor, out_word.at_floor);
          end
        end
      end
      if (push && !full) begin
        if (meter_bin(in_word, predicted)) begin
          if (pin_on && predicted !== pin_val) begin
            errors++;
            if (errors <= 10) $display("pinned loudness differs: exp %0d/%0b got %0d/%0b",
                                       pin_val.loudness_db, pin_val.at_floor,
                                       predicted.loudness_db, predicted.at_floor);
          end
          loudness_q = {loudness_q, predicted};
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (hold_go) begin
        hold_cnt = 2000;
        hold_go = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_bin(input blrm_in_t w, input bit pin, input blrm_out_t pv);
    push <= 1'b1;
    in_word <= w;
    pin_on <= pin;
    pin_val <= pv;
    @(posedge clk);
    while (full) @(posedge clk);
    while ($urandom_range(99) < send_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    pin_on <= 1'b0;
    @(posedge clk);
    while (loudness_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] nb, input logic [CFG_W-1:0] rate,
                            input logic [CFG_W-1:0] fdb, input logic [CFG_W-1:0] fe);
    drain();
    // let a bin-only tail finish its band divides
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NUM_BINS;
    cfg_wdata <= nb;
    @(posedge clk);
    cfg_index <= CFG_SAMPLE_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_index <= CFG_FLOOR_DB;
    cfg_wdata <= fdb;
    @(posedge clk);
    cfg_index <= CFG_FLOOR_ENERGY;
    cfg_wdata <= fe;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic blrm_in_t rand_bin();
    blrm_in_t w;
    int sh;
    logic [31:0] a, b, c, d;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    d = $urandom;
    sh = ($urandom_range(15) == 0) ? 0 : $urandom_range(0, 23);
    w.left_re = $signed(a[23:0]) >>> sh;
    w.left_im = $signed(b[23:0]) >>> sh;
    w.right_re = $signed(c[23:0]) >>> sh;
    w.right_im = $signed(d[23:0]) >>> sh;
    return w;
  endfunction

  initial begin
    row_t rows[12];
    blrm_out_t none;
    blrm_out_t floor_rst;
    int sent;
    int phase;
    int nb, rate, cnt;
    logic [DB_W-1:0] fdb;
    logic [FLOOR_E_W-1:0] fe;

    none = '0;
    floor_rst.loudness_db = FLOOR_DB_RST;
    floor_rst.at_floor = 1'b1;
    rows[0] = '{'0, 1'b0, none};
    rows[1] = '{'0, 1'b1, floor_rst};
    rows[2] = '{{SMIN, SMIN, SMIN, SMIN}, 1'b0, none};
    rows[3] = '{{SMIN, SMIN, SMIN, SMIN}, 1'b0, none};
    rows[4] = '{{SMAX, SMAX, SMAX, SMAX}, 1'b0, none};
    rows[5] = '{{SMAX, SMAX, SMAX, SMAX}, 1'b0, none};
    rows[6] = '{{SMAX, SMIN, -24'sd1, 24'sd1}, 1'b0, none};
    rows[7] = '{{SMIN, SMAX, 24'sd1, -24'sd1}, 1'b0, none};
    // one unit of energy over four items truncates to a zero mean
    rows[8] = '{{24'sd1, 24'sd0, 24'sd0, 24'sd0}, 1'b0, none};
    rows[9] = '{'0, 1'b1, floor_rst};
    rows[10] = '{{24'sd0, 24'sd4096, 24'sd0, 24'sd0}, 1'b0, none};
    rows[11] = '{{24'sd0, 24'sd0, 24'sd0, 24'sd4096}, 1'b0, none};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_regs(2, SAMPLE_RATE_RST, FLOOR_DB_RST, FLOOR_ENERGY_RST);
    foreach (rows[i]) send_bin(rows[i].w, rows[i].pin, rows[i].val);

    // clamp cases: one bin per spectrum under a saturated floor, then a zero floor
    write_regs(0, 0, 16'h8000, 48'hFFFF_FFFF_FFFF);
    repeat (4) send_bin(rand_bin(), 1'b0, none);
    write_regs(1, 8000, 0, 0);
    send_bin('0, 1'b0, none);
    repeat (4) send_bin(rand_bin(), 1'b0, none);

    // back-pressure: hold the receiver off while bins keep coming
    hold_go = 1'b1;
    repeat (60) send_bin(rand_bin(), 1'b0, none);
    drain();

    sent = 0;
    phase = 0;
    while (sent < 1400) begin
      case ($urandom_range(4))
        0:       nb = $urandom_range(2, 4);
        1:       nb = 129;
        default: nb = $urandom_range(1, 40);
      endcase
      case ($urandom_range(4))
        0:       rate = 0;
        1:       rate = 192000;
        2:       rate = 262143;
        3:       rate = 8000;
        default: rate = $urandom_range(8000, 192000);
      endcase
      fdb = 16'($urandom);
      fe = ($urandom_range(7) == 0) ? 48'({$urandom, $urandom})
                                    : 48'($urandom_range(0, 1 << 20));
      write_regs(nb, rate, fdb, fe);
      case (phase % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 78; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 78; end
        default: begin send_pct = 23; stall_pct = 23; end
      endcase
      cnt = $urandom_range(100, 200);
      repeat (cnt) send_bin(rand_bin(), 1'b0, none);
      sent += cnt;
      phase++;
    end

    // widest register value clamps to the full bin count; a short count
    // written afterwards ends the spectrum on the next bin
    send_pct = 0;
    stall_pct = 0;
    write_regs(8191, 48000, FLOOR_DB_RST, 4);
    repeat (300) send_bin(rand_bin(), 1'b0, none);
    write_regs(2, 48000, FLOOR_DB_RST, 4);
    send_bin(rand_bin(), 1'b0, none);

    drain();
    repeat (400) @(posedge clk);
    if (loudness_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
